>>> hw/rtl/tls_alpn_list_joiner_macros.svh
// ---------------------------------------------------------------------------
// tls_alpn_list_joiner_macros.svh
// Assertion helpers shared by the ALPN list joiner RTL.
// ---------------------------------------------------------------------------
`ifndef TLS_ALPN_LIST_JOINER_MACROS_SVH
`define TLS_ALPN_LIST_JOINER_MACROS_SVH

// Check an implication in the same cycle, outside reset.
`define TAJ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the following cycle, outside reset.
`define TAJ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tlsaj_pkg.sv
// ---------------------------------------------------------------------------
// tlsaj_pkg
// Types and constants of the ALPN list joiner.
// ---------------------------------------------------------------------------
package tlsaj_pkg;

  // Separator placed between consecutive protocol names
  localparam logic [7:0] SEP_CHAR = 8'h3B;
  // Bytes taken by the list length field
  localparam logic [16:0] LEN_FIELD_BYTES = 17'd2;
  // Capacity after reset
  localparam logic [15:0] CAPACITY_RESET = 16'd255;

  // One byte of the extension body
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] avail_len;
    logic        last_byte;
  } in_item_t;

  // One result: a character or the final count
  typedef struct packed {
    logic [7:0]  out_char;
    logic        is_final;
    logic [15:0] written_len;
  } out_item_t;

  // Parser phase
  typedef enum logic [3:0] {
    PH_HIGH = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_NAME = 4'b1000
  } phase_t;

endpackage

>>> hw/rtl/tls_alpn_list_joiner.sv
// Path: an accepted byte is held in the input register, then its results enter the queue.
// Throughput: one byte per cycle while each byte yields at most one result and the
// queue holds at most two; the output moves one result per cycle while res_ready
// is high, so bytes that yield two (separator or character plus final) can stall input.
// Reset: synchronous; clears parser state and the result queue, capacity = 255.
// ---------------------------------------------------------------------------
// tls_alpn_list_joiner
// Parses a TLS ALPN extension body byte by byte and streams the protocol
// names joined by ';', then a final item with the written length.
// ---------------------------------------------------------------------------
module tls_alpn_list_joiner (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  tlsaj_pkg::in_item_t byte_item,
  output logic                res_valid,
  input  logic                res_ready,
  output tlsaj_pkg::out_item_t res_item,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import tlsaj_pkg::*;

  // Input register
  logic     hold_valid;
  in_item_t hold;
  logic     adv;

  // Parser state
  phase_t      phase, phase_next;
  logic [16:0] list_end, list_end_next;
  logic [16:0] position, position_next;
  logic [7:0]  entry_left, entry_left_next;
  logic [15:0] written, written_next;
  logic        stopped, stopped_next;
  logic [15:0] capacity;

  // Result queue
  out_item_t   fifo [4];
  logic [1:0]  wptr, rptr;
  logic [2:0]  cnt;
  logic [1:0]  push_n;
  logic        pop;
  out_item_t   ent0, ent1;

  // Item processing
  phase_t      ph;
  logic [16:0] le, pos;
  logic [7:0]  el;
  logic [15:0] wr;
  logic        stp;
  logic [16:0] len_sum;
  logic [16:0] pos_inc;
  logic [17:0] end_chk;
  logic [17:0] room_chk;
  logic        char_ok;
  logic [7:0]  char_val;

  assign adv        = hold_valid && (cnt <= 3'd2);
  assign byte_ready = !hold_valid || adv;

  // Hold the accepted byte until the queue has room for two results
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_ready) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      hold <= byte_item;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Advance the parser by one byte
  always_comb begin
    ph  = hold.first_byte ? PH_HIGH : phase;
    le  = hold.first_byte ? {1'b0, hold.avail_len} : list_end;
    pos = hold.first_byte ? 17'd0 : position;
    el  = hold.first_byte ? 8'd0 : entry_left;
    wr  = hold.first_byte ? 16'd0 : written;
    stp = hold.first_byte ? 1'b0 : stopped;

    len_sum  = {1'b0, el, hold.data_byte} + LEN_FIELD_BYTES;
    pos_inc  = pos + 17'd1;
    end_chk  = {1'b0, pos_inc} + {10'd0, hold.data_byte};
    room_chk = {2'd0, wr} + {10'd0, hold.data_byte} + 18'd2;

    phase_next      = ph;
    list_end_next   = le;
    position_next   = pos;
    entry_left_next = el;
    written_next    = wr;
    stopped_next    = stp;
    char_ok         = 1'b0;
    char_val        = hold.data_byte;

    if (!stp) begin
      unique case (ph)
        PH_HIGH: begin
          if (hold.first_byte) begin
            entry_left_next = hold.data_byte;
            position_next   = 17'd1;
            phase_next      = PH_LOW;
          end
        end
        PH_LOW: begin
          if (len_sum > le) begin
            stopped_next = 1'b1;
          end else begin
            list_end_next   = len_sum;
            position_next   = 17'd2;
            entry_left_next = 8'd0;
            phase_next      = PH_LEN;
          end
        end
        PH_LEN: begin
          if (pos_inc < le) begin
            if (end_chk > {1'b0, le} || room_chk >= {2'd0, capacity}) begin
              stopped_next = 1'b1;
            end else begin
              if (wr != 16'd0) begin
                char_ok      = 1'b1;
                char_val     = SEP_CHAR;
                written_next = wr + 16'd1;
              end
              position_next = pos_inc;
              if (hold.data_byte != 8'd0) begin
                entry_left_next = hold.data_byte;
                phase_next      = PH_NAME;
              end
            end
          end else begin
            stopped_next = 1'b1;
          end
        end
        PH_NAME: begin
          char_ok         = 1'b1;
          written_next    = wr + 16'd1;
          position_next   = pos_inc;
          entry_left_next = el - 8'd1;
          if (el == 8'd1) begin
            phase_next = PH_LEN;
          end
        end
        default: begin
          stopped_next = stp;
        end
      endcase
    end

    // Close the body on the last byte
    if (hold.last_byte) begin
      phase_next      = PH_HIGH;
      stopped_next    = 1'b0;
      entry_left_next = 8'd0;
      position_next   = 17'd0;
    end

    ent0 = '{out_char: char_val, is_final: 1'b0, written_len: 16'd0};
    ent1 = '{out_char: 8'd0, is_final: 1'b1, written_len: written_next};
    if (!char_ok) begin
      ent0 = ent1;
    end
    push_n = adv ? ({1'b0, char_ok} + {1'b0, hold.last_byte}) : 2'd0;
  end

  // Commit parser state when the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HIGH;
      list_end   <= '0;
      position   <= '0;
      entry_left <= '0;
      written    <= '0;
      stopped    <= 1'b0;
    end else if (adv) begin
      phase      <= phase_next;
      list_end   <= list_end_next;
      position   <= position_next;
      entry_left <= entry_left_next;
      written    <= written_next;
      stopped    <= stopped_next;
    end
  end

  // Result queue: push up to two items, drop one per output handshake
  assign pop       = res_valid && res_ready;
  assign res_valid = (cnt != 3'd0);
  assign res_item  = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wptr] <= ent0;
    end
    if (push_n == 2'd2) begin
      fifo[wptr + 2'd1] <= ent1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr + push_n;
      rptr <= rptr + {1'b0, pop};
      cnt  <= cnt + {1'b0, push_n} - {2'd0, pop};
    end
  end

  `include "tls_alpn_list_joiner_macros.svh"

  `TAJ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= 3'd4, "result queue over capacity")
  `TAJ_ASSERT_IMP(a_room, push_n != 2'd0, cnt <= 3'd2, "push without room for two items")
  `TAJ_ASSERT_IMP(a_stopped_quiet, adv && stopped && !hold.first_byte && !hold.last_byte,
                  push_n == 2'd0, "character emitted after parsing stopped")
  `TAJ_ASSERT_NEXT(a_cnt_track, 1'b1,
                   cnt == $past(cnt) + {1'b0, $past(push_n)} - {2'd0, $past(pop)},
                   "queue count out of step with pushes and pops")

endmodule

>>> verif/tls_alpn_list_joiner_test.sv
// ---------------------------------------------------------------------------
// tls_alpn_list_joiner_test
// Feeds ALPN extension bodies into the list joiner, well-formed lists with
// random names plus broken ones, and checks every joined character and final
// count against a byte-level parser kept in a scoreboard.
// ---------------------------------------------------------------------------
module tls_alpn_list_joiner_test;
  import tlsaj_pkg::*;

  localparam int ITEM_TARGET    = 1050;
  localparam int RANDOM_PHASES  = 6;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic [7:0] byte_q_t[$];

  // Scoreboard: parses each accepted byte and holds the joined items due
  class alpn_join_scoreboard;
    out_item_t   expected_items[$];
    int          errors;
    logic [15:0] capacity;
    phase_t      phase;
    logic [16:0] list_end;
    logic [16:0] position;
    logic [7:0]  entry_left;
    logic [15:0] written;
    bit          stopped;

    function new();
      errors     = 0;
      capacity   = CAPACITY_RESET;
      phase      = PH_HIGH;
      list_end   = '0;
      position   = '0;
      entry_left = '0;
      written    = '0;
      stopped    = 1'b0;
    endfunction

    function int pending();
      return expected_items.size();
    endfunction

    function void expect_item(logic [7:0] ch, logic fin, logic [15:0] len);
      out_item_t it;
      it.out_char    = ch;
      it.is_final    = fin;
      it.written_len = len;
      expected_items.push_back(it);
    endfunction

    // Advance the parser by one body byte and queue what it gives out
    function void parse_body_byte(in_item_t it);
      int list_bytes;
      int next_pos;
      if (it.first_byte) begin
        phase      = PH_HIGH;
        position   = '0;
        entry_left = '0;
        written    = '0;
        stopped    = 1'b0;
        list_end   = {1'b0, it.avail_len};
      end
      if (!stopped) begin
        case (phase)
          PH_HIGH: begin
            // Ignore unmarked bytes while waiting for a start
            if (it.first_byte) begin
              entry_left = it.data_byte;
              position   = 17'd1;
              phase      = PH_LOW;
            end
          end
          PH_LOW: begin
            list_bytes = int'({entry_left, it.data_byte}) + 2;
            if (list_bytes > int'(list_end)) begin
              stopped = 1'b1;
            end else begin
              list_end   = list_bytes[16:0];
              position   = LEN_FIELD_BYTES;
              entry_left = '0;
              phase      = PH_LEN;
            end
          end
          PH_LEN: begin
            next_pos = int'(position) + 1;
            if (next_pos < int'(list_end)) begin
              if (next_pos + int'(it.data_byte) > int'(list_end) ||
                  int'(written) + int'(it.data_byte) + 2 >= int'(capacity)) begin
                stopped = 1'b1;
              end else begin
                if (written != 0) begin
                  expect_item(SEP_CHAR, 1'b0, 16'd0);
                  written = written + 16'd1;
                end
                position = next_pos[16:0];
                if (it.data_byte != 0) begin
                  entry_left = it.data_byte;
                  phase      = PH_NAME;
                end
              end
            end else begin
              stopped = 1'b1;
            end
          end
          default: begin
            expect_item(it.data_byte, 1'b0, 16'd0);
            written    = written + 16'd1;
            position   = position + 17'd1;
            entry_left = entry_left - 8'd1;
            if (entry_left == 0) phase = PH_LEN;
          end
        endcase
      end
      if (it.last_byte) begin
        expect_item(8'h00, 1'b1, written);
        phase      = PH_HIGH;
        stopped    = 1'b0;
        entry_left = '0;
        position   = '0;
      end
    endfunction

    task report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      errors++;
    endtask

    // Compare one result with the oldest expected item
    task check_joined_item(out_item_t got);
      out_item_t want;
      if (expected_items.size() == 0) begin
        report_mismatch("unexpected result", int'(got), 0);
        return;
      end
      want = expected_items.pop_front();
      if (got.out_char !== want.out_char)
        report_mismatch("out_char", int'(got.out_char), int'(want.out_char));
      if (got.is_final !== want.is_final)
        report_mismatch("is_final", int'(got.is_final), int'(want.is_final));
      if (got.written_len !== want.written_len)
        report_mismatch("written_len", int'(got.written_len), int'(want.written_len));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  in_item_t    byte_item;
  logic        res_valid;
  logic        res_ready;
  out_item_t   res_item;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  alpn_join_scoreboard sb = new();
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;
  int bytes_sent   = 0;
  int idle_cycles  = 0;

  tls_alpn_list_joiner dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Track accepted items on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_joined_item(res_item);
      if (byte_valid && byte_ready) sb.parse_body_byte(byte_item);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: short random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        res_ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Drive one body, one byte per item, with random gaps
  task automatic send_body(input byte_q_t bytes, input logic [15:0] avail,
                           input bit mark_first, input bit mark_last);
    in_item_t it;
    foreach (bytes[i]) begin
      it.data_byte  = bytes[i];
      it.first_byte = mark_first && (i == 0);
      it.avail_len  = (i == 0) ? avail : 16'($urandom_range(0, 65535));
      it.last_byte  = mark_last && (i == bytes.size() - 1);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      byte_valid <= 1'b1;
      byte_item  <= it;
      do @(posedge clk); while (!byte_ready);
      bytes_sent++;
    end
  endtask

  // Build a list with random names, sometimes broken, and send it
  task automatic send_random_body();
    byte_q_t     body;
    byte_q_t     names;
    byte_q_t     stray;
    int          len;
    int          list_len;
    int          cut;
    logic [15:0] avail;
    for (int e = $urandom_range(0, 5); e > 0; e--) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        9:       len = $urandom_range(9, 140);
        default: len = $urandom_range(1, 8);
      endcase
      names.push_back(len[7:0]);
      repeat (len) names.push_back(8'($urandom_range(0, 255)));
    end
    list_len = names.size();
    // Corrupt the list length now and then
    case ($urandom_range(0, 9))
      0: list_len = $urandom_range(0, 65535);
      1: list_len = (list_len > 3) ? list_len - $urandom_range(1, 3) : 0;
      2: list_len = list_len + $urandom_range(1, 3);
      default: ;
    endcase
    body.push_back(list_len[15:8]);
    body.push_back(list_len[7:0]);
    body = {body, names};
    repeat ($urandom_range(0, 2)) body.push_back(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 7))
      0:       avail = 16'($urandom_range(0, 65535));
      1:       avail = 16'(list_len + 1);
      default: avail = 16'(list_len + 2 + $urandom_range(0, 2));
    endcase
    // Occasionally lead with a stray unmarked byte
    if ($urandom_range(0, 14) == 0) begin
      stray.push_back(8'($urandom_range(0, 255)));
      send_body(stray, 16'($urandom_range(0, 65535)), 1'b0, 1'b0);
    end
    cut = $urandom_range(0, 9);
    if (cut == 0 && body.size() > 1) begin
      len = $urandom_range(1, body.size() - 1);
      while (body.size() > len) void'(body.pop_back());
    end
    send_body(body, avail, 1'b1, cut != 1);
  endtask

  // Write capacity once the block has drained
  task automatic load_capacity(input logic [15:0] value);
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.capacity = value;
  endtask

  initial begin
    logic [15:0] phase_caps [RANDOM_PHASES];
    rst         <= 1'b1;
    byte_valid  <= 1'b0;
    byte_item   <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First and last on one byte
    send_body('{8'h00}, 16'd0, 1'b1, 1'b1);
    // Unmarked byte while waiting for a start
    send_body('{8'hFF}, 16'hFFFF, 1'b0, 1'b0);
    // Names, empty entry and a byte past the list end
    send_body('{8'h00, 8'h08, 8'h02, 8'h68, 8'h32, 8'h00, 8'h03, 8'hFF, 8'h00,
                8'h61, 8'h7E}, 16'd11, 1'b1, 1'b1);
    // List longer than the available bytes
    send_body('{8'hFF, 8'hFF, 8'h05}, 16'hFFFF, 1'b1, 1'b1);
    // Entry overrunning the list end
    send_body('{8'h00, 8'h02, 8'h05}, 16'd4, 1'b1, 1'b1);
    // Single list byte left at an entry length
    send_body('{8'h00, 8'h01, 8'h00}, 16'd3, 1'b1, 1'b1);
    // Last marked inside a name
    send_body('{8'h00, 8'h04, 8'h03, 8'h74}, 16'd6, 1'b1, 1'b1);
    // Output buffer full on the second entry
    load_capacity(16'd4);
    send_body('{8'h00, 8'h04, 8'h01, 8'h63, 8'h01, 8'h64}, 16'd6, 1'b1, 1'b1);

    // Random lists over several capacities; hold results once to back up
    phase_caps = '{16'd2, 16'hFFFF, 16'd3, 16'd16, 16'($urandom_range(2, 65535)),
                   CAPACITY_RESET};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_capacity(phase_caps[p]);
      if (p == 1) hold_request = 1'b1;
      if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
      while (bytes_sent < ITEM_TARGET * (p + 1) / RANDOM_PHASES) send_random_body();
    end

    // Drain and finish
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
